// File: hdl/bipartite_degree_preserving_rewire_defines.svh
// Assertion macros for the degree-preserving rewire block.
// Expect i_clk and i_rst_n in the scope where they are used.
`ifndef BIPARTITE_DEGREE_PRESERVING_REWIRE_DEFINES_SVH
`define BIPARTITE_DEGREE_PRESERVING_REWIRE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define BRW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("brw assertion failed");
// next-cycle implication
`define BRW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brw assertion failed");
`else
`define BRW_ASSERT_NOW(lbl, ante, cons)
`define BRW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/brw_pkg.sv
// Shared types, constants and the LFSR step for the rewire block.
// No dependencies.
package brw_pkg;

    localparam int ID_W    = 16;
    localparam int IDX_W   = 10;
    localparam int OP_W    = 2;
    localparam int STS_W   = 2;
    localparam int CNTO_W  = 11;
    localparam int LFSR_W  = 32;
    localparam logic [LFSR_W-1:0] LFSR_MASK = 32'hD000_0001;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RAND  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_CLR,
        S_ADD_RD, S_ADD_CMP, S_ADD_CHK, S_ADD_UPD,
        S_RT_INIT, S_RS_RD, S_RS_WR,
        S_SH_CHK, S_SH_DRAW, S_SH_WAIT, S_SH_RDA, S_SH_RDB, S_SH_WA, S_SH_WB,
        S_P_CHK, S_P_RD, S_P_S,
        S_ST_CHK, S_ST_WAIT, S_SR_RD, S_SR_T, S_SR_CMP,
        S_PL_WR, S_PL_FILL, S_PL_WA, S_PL_WB,
        S_LC_INIT, S_LC_RD, S_LC_WR,
        S_RD_CHK, S_RD_RD, S_RD_CMP, S_RD_T, S_RD_T2,
        S_DONE
    } t_state;

    // Galois LFSR, shift right
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] v;
        v = s >> 1;
        if (s[0]) begin
            v = v ^ LFSR_MASK;
        end
        return v;
    endfunction

endpackage

// File: hdl/brw_cmd_if.sv
// Command channel: operation plus edge payload, valid/ready.
// Depends on brw_pkg.
interface brw_cmd_if;
    import brw_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ID_W-1:0]  source_id;
    logic [ID_W-1:0]  target_id;
    logic [IDX_W-1:0] edge_index;

    modport source(output valid, operation, source_id, target_id, edge_index, input ready);
    modport sink(input valid, operation, source_id, target_id, edge_index, output ready);
endinterface

// File: hdl/brw_rsp_if.sv
// Response channel: status, counts and read edge, valid/ready.
// Depends on brw_pkg.
interface brw_rsp_if;
    import brw_pkg::*;
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [CNTO_W-1:0] connected_count;
    logic [CNTO_W-1:0] edge_count;
    logic [ID_W-1:0]   out_source_id;
    logic [ID_W-1:0]   out_target_id;

    modport source(output valid, status, connected_count, edge_count, out_source_id,
                   out_target_id, input ready);
    modport sink(input valid, status, connected_count, edge_count, out_source_id,
                 out_target_id, output ready);
endinterface

// File: hdl/bipartite_degree_preserving_rewire.sv
// Degree-preserving random rewiring of a directed bipartite graph.
// Top level: sequencer, vertex/edge memories. Uses brw_pkg, brw_cmd_if,
// brw_rsp_if, brw_mod and the defines header.
//
// Usage: i_cmd carries one command per transaction (clear, add edge,
// randomize, read edge); every command yields exactly one o_rsp transaction
// with status, placed count, loaded count and, for a good read, the edge ids.
// i_seed_we/i_seed_wdata load the LFSR seed register, used on the next clear.
// Work per command:
//   clear     identity sweep of the source order and link marks
//   add edge  search of the id memories, one compare per id-memory read
//   read      walk over the sources up to the one that holds the edge
//   randomize target and source setup, shuffle of the source order, then per
//             stub random probes; each random draw waits in the shared remainder unit.
// One command at a time; i_cmd.ready is high only while the sequencer idles.
// The response sits in an output register, so a new command can be taken
// in the cycle the pending response is taken.
// Reset (synchronous, active low): counts zero, LFSR one, seed one, then a
// clearing pass over the source order and link marks during which no
// command is taken. A stalled o_rsp holds its payload and blocks new
// commands until it is taken.
`include "bipartite_degree_preserving_rewire_defines.svh"
module bipartite_degree_preserving_rewire #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    brw_cmd_if.sink                     i_cmd,
    brw_rsp_if.source                   o_rsp,
    input  logic                        i_seed_we,
    input  logic [brw_pkg::LFSR_W-1:0]  i_seed_wdata
);
    import brw_pkg::*;

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int DW   = $clog2(MAX_EDGES + 1);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int CMPW = (DW > IDX_W) ? DW : IDX_W;

    // ---------------- memories ----------------
    logic [ID_W-1:0] sid_mem   [MAX_VERTICES];
    logic [ID_W-1:0] tid_mem   [MAX_VERTICES];
    logic [DW-1:0]   sdeg_mem  [MAX_VERTICES];
    logic [DW-1:0]   tdeg_mem  [MAX_VERTICES];
    logic [DW-1:0]   sfill_mem [MAX_VERTICES];
    logic [DW-1:0]   tfill_mem [MAX_VERTICES];
    logic [DW-1:0]   sbase_mem [MAX_VERTICES];
    logic [VW-1:0]   sord_mem  [MAX_VERTICES];
    logic [VW-1:0]   cand_mem  [MAX_VERTICES];
    logic            lnk_mem   [MAX_VERTICES];
    logic [VW-1:0]   stub_mem  [MAX_EDGES];

    logic we_sid, we_tid, we_sdeg, we_tdeg, we_sfill, we_tfill;
    logic we_sbase, we_sord, we_cand, we_lnk, we_stub;
    logic [VW-1:0] wa_sid, wa_tid, wa_sdeg, wa_tdeg, wa_sfill, wa_tfill;
    logic [VW-1:0] wa_sbase, wa_sord, wa_cand, wa_lnk;
    logic [EW-1:0] wa_stub;
    logic [ID_W-1:0] wd_sid, wd_tid;
    logic [DW-1:0] wd_sdeg, wd_tdeg, wd_sfill, wd_tfill, wd_sbase;
    logic [VW-1:0] wd_sord, wd_cand, wd_stub;
    logic          wd_lnk;
    logic [VW-1:0] ra_sid, ra_tid, ra_sdeg, ra_tdeg, ra_sfill, ra_tfill;
    logic [VW-1:0] ra_sbase, ra_sord, ra_cand, ra_lnk;
    logic [EW-1:0] ra_stub;

    logic [ID_W-1:0] r_sid_rd, r_tid_rd;
    logic [DW-1:0]   r_sdeg_rd, r_tdeg_rd, r_sfill_rd, r_tfill_rd, r_sbase_rd;
    logic [VW-1:0]   r_sord_rd, r_cand_rd, r_stub_rd;
    logic            r_lnk_rd;

    always_ff @(posedge i_clk) begin
        if (we_sid)   sid_mem[wa_sid]     <= wd_sid;
        if (we_tid)   tid_mem[wa_tid]     <= wd_tid;
        if (we_sdeg)  sdeg_mem[wa_sdeg]   <= wd_sdeg;
        if (we_tdeg)  tdeg_mem[wa_tdeg]   <= wd_tdeg;
        if (we_sfill) sfill_mem[wa_sfill] <= wd_sfill;
        if (we_tfill) tfill_mem[wa_tfill] <= wd_tfill;
        if (we_sbase) sbase_mem[wa_sbase] <= wd_sbase;
        if (we_sord)  sord_mem[wa_sord]   <= wd_sord;
        if (we_cand)  cand_mem[wa_cand]   <= wd_cand;
        if (we_lnk)   lnk_mem[wa_lnk]     <= wd_lnk;
        if (we_stub)  stub_mem[wa_stub]   <= wd_stub;
        r_sid_rd   <= sid_mem[ra_sid];
        r_tid_rd   <= tid_mem[ra_tid];
        r_sdeg_rd  <= sdeg_mem[ra_sdeg];
        r_tdeg_rd  <= tdeg_mem[ra_tdeg];
        r_sfill_rd <= sfill_mem[ra_sfill];
        r_tfill_rd <= tfill_mem[ra_tfill];
        r_sbase_rd <= sbase_mem[ra_sbase];
        r_sord_rd  <= sord_mem[ra_sord];
        r_cand_rd  <= cand_mem[ra_cand];
        r_lnk_rd   <= lnk_mem[ra_lnk];
        r_stub_rd  <= stub_mem[ra_stub];
    end

    // ---------------- sequencer registers ----------------
    t_state            r_state, n_state;
    logic [LFSR_W-1:0] r_seed;
    logic [LFSR_W-1:0] r_lfsr, n_lfsr;
    logic [CW-1:0]     r_scount, n_scount, r_tcount, n_tcount;
    logic [CW-1:0]     r_i, n_i, r_cnt, n_cnt, r_ncand, n_ncand;
    logic [DW-1:0]     r_loaded, n_loaded, r_placed, n_placed;
    logic [DW-1:0]     r_j, n_j, r_base, n_base, r_deg, n_deg;
    logic [DW-1:0]     r_fill, n_fill, r_k, n_k, r_rk, n_rk;
    logic [VW-1:0]     r_s, n_s, r_t, n_t, r_off, n_off, r_a, n_a;
    logic [VW-1:0]     r_sidx, n_sidx, r_tidx, n_tidx;
    logic              r_sfound, n_sfound, r_tfound, n_tfound;
    logic [ID_W-1:0]   r_sid, n_sid, r_tid, n_tid, r_sidv, n_sidv;
    logic [ID_W-1:0]   r_osid, n_osid, r_otid, n_otid;
    logic [IDX_W-1:0]  r_idx, n_idx;
    t_status           r_status, n_status;
    // response register
    logic              r_ovalid, n_ovalid;
    t_status           r_o_status, n_o_status;
    logic [CNTO_W-1:0] r_o_conn, n_o_conn, r_o_edges, n_o_edges;
    logic [ID_W-1:0]   r_o_sid, n_o_sid, r_o_tid, n_o_tid;

    logic              cmd_acc;
    logic [CW-1:0]     search_max;
    logic              add_fail;
    logic              sr_hit;
    logic              ts_full;
    logic [DW-1:0]     tfill_inc;
    logic              stub_done;
    logic              mod_start;
    logic [LFSR_W-1:0] lfsr_step;
    logic [CW-1:0]     mod_b;
    logic              mod_done;
    logic [CW-1:0]     mod_rem;
    logic [VW-1:0]     off_inc;

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_ovalid || o_rsp.ready);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign search_max  = (r_scount > r_tcount) ? r_scount : r_tcount;
    assign add_fail    = (r_loaded == DW'(MAX_EDGES))
                       || (!r_sfound && (r_scount == CW'(MAX_VERTICES)))
                       || (!r_tfound && (r_tcount == CW'(MAX_VERTICES)));
    assign sr_hit      = !r_lnk_rd && (r_sidv != r_tid_rd);
    assign tfill_inc   = r_tfill_rd + 1'b1;
    assign ts_full     = (tfill_inc == r_tdeg_rd);
    assign stub_done   = (r_j == r_deg) || (r_ncand == '0);
    assign lfsr_step   = lfsr_next(r_lfsr);
    assign off_inc     = r_off + 1'b1;

    brw_mod #(.BW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (lfsr_step),
        .i_divisor  (mod_b),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT, S_CLR: begin
                if (r_i == CW'(MAX_VERTICES - 1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (cmd_acc) begin
                    unique case (t_op'(i_cmd.operation))
                        OP_CLEAR: n_state = S_CLR;
                        OP_ADD:   n_state = (search_max == '0) ? S_ADD_CHK : S_ADD_RD;
                        OP_RAND:  n_state = S_RT_INIT;
                        OP_READ:  n_state = S_RD_CHK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD:  n_state = S_ADD_CMP;
            S_ADD_CMP: n_state = (r_i + 1'b1 == search_max) ? S_ADD_CHK : S_ADD_RD;
            S_ADD_CHK: n_state = add_fail ? S_DONE : S_ADD_UPD;
            S_ADD_UPD: n_state = S_DONE;
            S_RT_INIT: n_state = (r_i == r_tcount) ? S_RS_RD : S_RT_INIT;
            S_RS_RD:   n_state = (r_i == r_scount) ? S_SH_CHK : S_RS_WR;
            S_RS_WR:   n_state = S_RS_RD;
            S_SH_CHK:  n_state = (r_i <= CW'(1)) ? S_P_CHK : S_SH_DRAW;
            S_SH_DRAW: n_state = S_SH_WAIT;
            S_SH_WAIT: n_state = mod_done ? S_SH_RDA : S_SH_WAIT;
            S_SH_RDA:  n_state = S_SH_RDB;
            S_SH_RDB:  n_state = S_SH_WA;
            S_SH_WA:   n_state = S_SH_WB;
            S_SH_WB:   n_state = S_SH_CHK;
            S_P_CHK:   n_state = (r_i == r_scount) ? S_DONE : S_P_RD;
            S_P_RD:    n_state = S_P_S;
            S_P_S:     n_state = S_ST_CHK;
            S_ST_CHK:  n_state = stub_done ? S_LC_INIT : S_ST_WAIT;
            S_ST_WAIT: n_state = mod_done ? S_SR_RD : S_ST_WAIT;
            S_SR_RD:   n_state = S_SR_T;
            S_SR_T:    n_state = S_SR_CMP;
            S_SR_CMP: begin
                if (sr_hit) begin
                    n_state = S_PL_WR;
                end else if (r_cnt + 1'b1 == r_ncand) begin
                    n_state = S_LC_INIT;
                end else begin
                    n_state = S_SR_RD;
                end
            end
            S_PL_WR:   n_state = S_PL_FILL;
            S_PL_FILL: n_state = ts_full ? S_PL_WA : S_ST_CHK;
            S_PL_WA:   n_state = S_PL_WB;
            S_PL_WB:   n_state = S_ST_CHK;
            S_LC_INIT: n_state = S_LC_RD;
            S_LC_RD:   n_state = (r_k == r_fill) ? S_P_CHK : S_LC_WR;
            S_LC_WR:   n_state = S_LC_RD;
            S_RD_CHK:  n_state = (CMPW'(r_idx) >= CMPW'(r_placed)) ? S_DONE : S_RD_RD;
            S_RD_RD:   n_state = (r_i == r_scount) ? S_DONE : S_RD_CMP;
            S_RD_CMP:  n_state = (r_rk < r_sfill_rd) ? S_RD_T : S_RD_RD;
            S_RD_T:    n_state = S_RD_T2;
            S_RD_T2:   n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb begin
        n_lfsr = r_lfsr;     n_scount = r_scount; n_tcount = r_tcount;
        n_i = r_i;           n_cnt = r_cnt;       n_ncand = r_ncand;
        n_loaded = r_loaded; n_placed = r_placed; n_j = r_j;
        n_base = r_base;     n_deg = r_deg;       n_fill = r_fill;
        n_k = r_k;           n_rk = r_rk;         n_s = r_s;
        n_t = r_t;           n_off = r_off;       n_a = r_a;
        n_sidx = r_sidx;     n_tidx = r_tidx;     n_sfound = r_sfound;
        n_tfound = r_tfound; n_sid = r_sid;       n_tid = r_tid;
        n_sidv = r_sidv;     n_osid = r_osid;     n_otid = r_otid;
        n_idx = r_idx;       n_status = r_status;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_o_status = r_o_status; n_o_conn = r_o_conn; n_o_edges = r_o_edges;
        n_o_sid = r_o_sid;   n_o_tid = r_o_tid;

        we_sid = 1'b0; we_tid = 1'b0; we_sdeg = 1'b0; we_tdeg = 1'b0;
        we_sfill = 1'b0; we_tfill = 1'b0; we_sbase = 1'b0; we_sord = 1'b0;
        we_cand = 1'b0; we_lnk = 1'b0; we_stub = 1'b0;
        wa_sid = '0; wa_tid = '0; wa_sdeg = '0; wa_tdeg = '0; wa_sfill = '0;
        wa_tfill = '0; wa_sbase = '0; wa_sord = '0; wa_cand = '0; wa_lnk = '0;
        wa_stub = '0;
        wd_sid = r_sid; wd_tid = r_tid; wd_sdeg = '0; wd_tdeg = '0;
        wd_sfill = '0; wd_tfill = '0; wd_sbase = '0; wd_sord = '0;
        wd_cand = '0; wd_lnk = 1'b0; wd_stub = r_t;
        ra_sid = '0; ra_tid = '0; ra_sdeg = '0; ra_tdeg = '0; ra_sfill = '0;
        ra_tfill = '0; ra_sbase = '0; ra_sord = '0; ra_cand = '0; ra_lnk = '0;
        ra_stub = '0;
        mod_start = 1'b0;
        mod_b = r_i;

        unique case (r_state)
            S_INIT, S_CLR: begin
                // identity source order, link marks cleared
                we_sord = 1'b1; wa_sord = VW'(r_i); wd_sord = VW'(r_i);
                we_lnk  = 1'b1; wa_lnk  = VW'(r_i); wd_lnk  = 1'b0;
                n_i = r_i + 1'b1;
            end
            S_IDLE: begin
                if (cmd_acc) begin
                    n_sid = i_cmd.source_id;
                    n_tid = i_cmd.target_id;
                    n_idx = i_cmd.edge_index;
                    n_status = STS_OK;
                    n_osid = '0;
                    n_otid = '0;
                    n_i = '0;
                    unique case (t_op'(i_cmd.operation))
                        OP_CLEAR: begin
                            n_scount = '0; n_tcount = '0;
                            n_loaded = '0; n_placed = '0;
                            n_lfsr = (r_seed == '0) ? LFSR_W'(1) : r_seed;
                        end
                        OP_ADD: begin
                            n_sfound = 1'b0;
                            n_tfound = 1'b0;
                        end
                        OP_RAND: begin
                            n_ncand = r_tcount;
                            n_placed = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                ra_sid = VW'(r_i);
                ra_tid = VW'(r_i);
            end
            S_ADD_CMP: begin
                if (!r_sfound && (r_i < r_scount) && (r_sid_rd == r_sid)) begin
                    n_sfound = 1'b1;
                    n_sidx = VW'(r_i);
                end
                if (!r_tfound && (r_i < r_tcount) && (r_tid_rd == r_tid)) begin
                    n_tfound = 1'b1;
                    n_tidx = VW'(r_i);
                end
                n_i = r_i + 1'b1;
            end
            S_ADD_CHK: begin
                n_s = r_sfound ? r_sidx : VW'(r_scount);
                n_t = r_tfound ? r_tidx : VW'(r_tcount);
                ra_sdeg = r_sfound ? r_sidx : VW'(r_scount);
                ra_tdeg = r_tfound ? r_tidx : VW'(r_tcount);
                if (add_fail) begin
                    n_status = STS_FULL;
                end
            end
            S_ADD_UPD: begin
                we_sdeg = 1'b1; wa_sdeg = r_s;
                wd_sdeg = r_sfound ? r_sdeg_rd + 1'b1 : DW'(1);
                we_tdeg = 1'b1; wa_tdeg = r_t;
                wd_tdeg = r_tfound ? r_tdeg_rd + 1'b1 : DW'(1);
                if (!r_sfound) begin
                    we_sid = 1'b1; wa_sid = r_s;
                    n_scount = r_scount + 1'b1;
                end
                if (!r_tfound) begin
                    we_tid = 1'b1; wa_tid = r_t;
                    n_tcount = r_tcount + 1'b1;
                end
                n_loaded = r_loaded + 1'b1;
                n_placed = '0;
            end
            S_RT_INIT: begin
                if (r_i == r_tcount) begin
                    n_i = '0;
                    n_base = '0;
                end else begin
                    we_cand  = 1'b1; wa_cand  = VW'(r_i); wd_cand = VW'(r_i);
                    we_lnk   = 1'b1; wa_lnk   = VW'(r_i); wd_lnk  = 1'b0;
                    we_tfill = 1'b1; wa_tfill = VW'(r_i); wd_tfill = '0;
                    n_i = r_i + 1'b1;
                end
            end
            S_RS_RD: begin
                ra_sdeg = VW'(r_i);
                if (r_i == r_scount) begin
                    n_i = r_scount;
                end
            end
            S_RS_WR: begin
                // slot base is the running sum of source degrees
                we_sbase = 1'b1; wa_sbase = VW'(r_i); wd_sbase = r_base;
                we_sfill = 1'b1; wa_sfill = VW'(r_i); wd_sfill = '0;
                n_base = r_base + r_sdeg_rd;
                n_i = r_i + 1'b1;
            end
            S_SH_CHK: begin
                if (r_i <= CW'(1)) begin
                    n_i = '0;
                end
            end
            S_SH_DRAW: begin
                n_lfsr = lfsr_step;
                mod_start = 1'b1;
                mod_b = r_i;
            end
            S_SH_WAIT: begin
                if (mod_done) begin
                    n_off = VW'(mod_rem);
                end
            end
            S_SH_RDA: begin
                ra_sord = VW'(r_i - 1'b1);
            end
            S_SH_RDB: begin
                n_a = r_sord_rd;
                ra_sord = r_off;
            end
            S_SH_WA: begin
                we_sord = 1'b1; wa_sord = VW'(r_i - 1'b1); wd_sord = r_sord_rd;
            end
            S_SH_WB: begin
                we_sord = 1'b1; wa_sord = r_off; wd_sord = r_a;
                n_i = r_i - 1'b1;
            end
            S_P_CHK: begin
                ra_sord = VW'(r_i);
            end
            S_P_RD: begin
                n_s = r_sord_rd;
                ra_sbase = r_sord_rd;
                ra_sdeg  = r_sord_rd;
                ra_sid   = r_sord_rd;
            end
            S_P_S: begin
                n_base = r_sbase_rd;
                n_deg  = r_sdeg_rd;
                n_sidv = r_sid_rd;
                n_j    = '0;
                n_fill = '0;
            end
            S_ST_CHK: begin
                if (!stub_done) begin
                    n_lfsr = lfsr_step;
                    mod_start = 1'b1;
                    mod_b = r_ncand;
                end
            end
            S_ST_WAIT: begin
                if (mod_done) begin
                    n_off = VW'(mod_rem);
                    n_cnt = '0;
                end
            end
            S_SR_RD: begin
                ra_cand = r_off;
            end
            S_SR_T: begin
                n_t = r_cand_rd;
                ra_lnk = r_cand_rd;
                ra_tid = r_cand_rd;
            end
            S_SR_CMP: begin
                if (!sr_hit) begin
                    // circular probe over the live candidates
                    n_off = (CW'(off_inc) == r_ncand) ? '0 : off_inc;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PL_WR: begin
                we_stub = 1'b1; wa_stub = EW'(r_base + r_j); wd_stub = r_t;
                we_lnk  = 1'b1; wa_lnk  = r_t; wd_lnk = 1'b1;
                n_placed = r_placed + 1'b1;
                n_fill = r_fill + 1'b1;
                n_j = r_j + 1'b1;
                ra_tfill = r_t;
                ra_tdeg  = r_t;
            end
            S_PL_FILL: begin
                we_tfill = 1'b1; wa_tfill = r_t; wd_tfill = tfill_inc;
                if (ts_full) begin
                    // target used up: swap it past the end of the list
                    n_ncand = r_ncand - 1'b1;
                    ra_cand = VW'(r_ncand - 1'b1);
                end
            end
            S_PL_WA: begin
                we_cand = 1'b1; wa_cand = r_off; wd_cand = r_cand_rd;
            end
            S_PL_WB: begin
                we_cand = 1'b1; wa_cand = VW'(r_ncand); wd_cand = r_t;
            end
            S_LC_INIT: begin
                we_sfill = 1'b1; wa_sfill = r_s; wd_sfill = r_fill;
                n_k = '0;
            end
            S_LC_RD: begin
                ra_stub = EW'(r_base + r_k);
                if (r_k == r_fill) begin
                    n_i = r_i + 1'b1;
                end
            end
            S_LC_WR: begin
                we_lnk = 1'b1; wa_lnk = r_stub_rd; wd_lnk = 1'b0;
                n_k = r_k + 1'b1;
            end
            S_RD_CHK: begin
                if (CMPW'(r_idx) >= CMPW'(r_placed)) begin
                    n_status = STS_RANGE;
                end else begin
                    n_rk = DW'(r_idx);
                    n_base = '0;
                    n_i = '0;
                end
            end
            S_RD_RD: begin
                ra_sfill = VW'(r_i);
                ra_sdeg  = VW'(r_i);
                if (r_i == r_scount) begin
                    n_status = STS_RANGE;
                end
            end
            S_RD_CMP: begin
                if (r_rk < r_sfill_rd) begin
                    ra_sid  = VW'(r_i);
                    ra_stub = EW'(r_base + r_rk);
                end else begin
                    n_rk = r_rk - r_sfill_rd;
                    n_base = r_base + r_sdeg_rd;
                    n_i = r_i + 1'b1;
                end
            end
            S_RD_T: begin
                n_osid = r_sid_rd;
                ra_tid = r_stub_rd;
            end
            S_RD_T2: begin
                n_otid = r_tid_rd;
            end
            S_DONE: begin
                n_ovalid   = 1'b1;
                n_o_status = r_status;
                n_o_conn   = CNTO_W'(r_placed);
                n_o_edges  = CNTO_W'(r_loaded);
                n_o_sid    = (r_status == STS_OK) ? r_osid : '0;
                n_o_tid    = (r_status == STS_OK) ? r_otid : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_seed   <= LFSR_W'(1);
            r_lfsr   <= LFSR_W'(1);
            r_scount <= '0;
            r_tcount <= '0;
            r_loaded <= '0;
            r_placed <= '0;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
            r_lfsr   <= n_lfsr;
            r_scount <= n_scount;
            r_tcount <= n_tcount;
            r_loaded <= n_loaded;
            r_placed <= n_placed;
            r_i      <= n_i;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;   r_ncand <= n_ncand; r_j <= n_j;
        r_base <= n_base; r_deg <= n_deg;     r_fill <= n_fill;
        r_k <= n_k;       r_rk <= n_rk;       r_s <= n_s;
        r_t <= n_t;       r_off <= n_off;     r_a <= n_a;
        r_sidx <= n_sidx; r_tidx <= n_tidx;   r_sfound <= n_sfound;
        r_tfound <= n_tfound; r_sid <= n_sid; r_tid <= n_tid;
        r_sidv <= n_sidv; r_osid <= n_osid;   r_otid <= n_otid;
        r_idx <= n_idx;   r_status <= n_status;
        r_o_status <= n_o_status; r_o_conn <= n_o_conn;
        r_o_edges <= n_o_edges;   r_o_sid <= n_o_sid; r_o_tid <= n_o_tid;
    end

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.connected_count = r_o_conn;
    assign o_rsp.edge_count      = r_o_edges;
    assign o_rsp.out_source_id   = r_o_sid;
    assign o_rsp.out_target_id   = r_o_tid;

    `BRW_ASSERT_NOW(a_placed_le_loaded, 1'b1, r_placed <= r_loaded)
    `BRW_ASSERT_NOW(a_ncand_le_targets, r_state == S_ST_CHK, r_ncand <= r_tcount)
    `BRW_ASSERT_NOW(a_fill_tracks_stub, r_state == S_ST_CHK, (r_j <= r_deg) && (r_fill == r_j))
    `BRW_ASSERT_NEXT(a_done_to_valid, r_state == S_DONE, r_ovalid)
endmodule

// File: hdl/brw_mod.sv
// Shared restoring remainder unit: 32-bit dividend mod BW-bit divisor,
// one bit per cycle. Depends on brw_pkg and the defines header.
`include "bipartite_degree_preserving_rewire_defines.svh"
module brw_mod #(
    parameter int BW = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [brw_pkg::LFSR_W-1:0]   i_dividend,
    input  logic [BW-1:0]                i_divisor,
    output logic                         o_done,
    output logic [BW-1:0]                o_rem
);
    import brw_pkg::*;

    localparam int CNT_W = $clog2(LFSR_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [LFSR_W-1:0] r_a;
    logic [BW-1:0]     r_r;
    logic [BW-1:0]     r_div;
    logic [BW:0]       trial;
    logic [BW-1:0]     n_r;

    always_comb begin
        trial = {r_r, r_a[LFSR_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_r = BW'(trial - {1'b0, r_div});
        end else begin
            n_r = BW'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_dividend;
                r_r    <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_r <= n_r;
                r_a <= r_a << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LFSR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_r;

    `BRW_ASSERT_NEXT(a_mod_start, i_start, r_busy)
    `BRW_ASSERT_NOW(a_mod_rem, r_done && (r_div != '0), r_r < r_div)
    `BRW_ASSERT_NOW(a_mod_done_idle, r_done, !r_busy)
endmodule
